### hdl/echo_bucket_window_detector_macros.svh
`ifndef ECHO_BUCKET_WINDOW_DETECTOR_MACROS_SVH
`define ECHO_BUCKET_WINDOW_DETECTOR_MACROS_SVH

// Same-cycle implication, masked while in reset.
`define EBWD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while in reset.
`define EBWD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Checked through reset as well.
`define EBWD_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

### hdl/ebwd_pkg.sv
package ebwd_pkg;

    localparam int NUM_BUCKETS = 32;
    localparam int BN_W        = $clog2(NUM_BUCKETS);

    localparam int SPB_W      = 8;
    localparam int SB_W       = 5;
    localparam int THR_W      = 10;
    localparam int CNT_W      = 8;
    localparam int SUM_W      = 10;
    localparam int OUT_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [SPB_W-1:0] SPB_RESET = 8'd64;
    localparam logic [SB_W-1:0]  SB_RESET  = 5'd6;
    localparam logic [THR_W-1:0] THR_RESET = 10'd8;

    localparam logic [BN_W-1:0]         LAST_BUCKET = BN_W'(NUM_BUCKETS - 1);
    localparam logic signed [OUT_W-1:0] ECHO_NONE   = -6'sd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLES_PER_BUCKET = 2'd0,
        CFG_START_BUCKET       = 2'd1,
        CFG_HIT_THRESHOLD      = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [SPB_W-1:0] samples_per_bucket;
        logic [SB_W-1:0]  start_bucket;
        logic [THR_W-1:0] hit_threshold;
    } cfg_t;

    typedef struct packed {
        logic                     valid;
        logic signed [OUT_W-1:0]  bucket;
    } res_t;

endpackage

### hdl/ebwd_cfg_regs.sv
module ebwd_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ebwd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ebwd_pkg::CFG_DATA_W-1:0] cfg_data,
    output ebwd_pkg::cfg_t                  cfg
);
    import ebwd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_SAMPLES_PER_BUCKET: cfg_next.samples_per_bucket = cfg_data[SPB_W-1:0];
                CFG_START_BUCKET:       cfg_next.start_bucket       = cfg_data[SB_W-1:0];
                CFG_HIT_THRESHOLD:      cfg_next.hit_threshold      = cfg_data[THR_W-1:0];
                default:                cfg_next = cfg_reg; // no register there
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.samples_per_bucket <= SPB_RESET;
            cfg_reg.start_bucket       <= SB_RESET;
            cfg_reg.hit_threshold      <= THR_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hdl/ebwd_core.sv
module ebwd_core (
    input  logic           clk,
    input  logic           rst_n,
    input  ebwd_pkg::cfg_t cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           start_req,
    input  logic           edge_req,
    input  logic           res_space,
    output ebwd_pkg::res_t res
);
    import ebwd_pkg::*;

    // input word register
    logic pipe_valid_reg, pipe_valid_next;
    logic start_reg, edge_reg;

    // measurement state
    logic             active_reg, active_next;
    logic [CNT_W-1:0] tick_reg, tick_next;
    logic [BN_W-1:0]  bn_reg, bn_next;
    logic [CNT_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0] prev_reg, prev_next;
    logic [CNT_W-1:0] old_reg, old_next;
    logic             found_reg, found_next;
    logic [BN_W-1:0]  idx_reg, idx_next;

    logic             step_en;
    logic             act;
    logic [CNT_W-1:0] tick_b, cur_b, prev_b, old_b, cur_inc, tick_inc;
    logic [BN_W-1:0]  bn_b, w;
    logic             found_b;
    logic [SPB_W-1:0] span;
    logic [SUM_W-1:0] sum;
    logic             complete, hit;

    assign step_en  = pipe_valid_reg && res_space;
    assign in_ready = !pipe_valid_reg || res_space;

    always_comb
    begin
        pipe_valid_next = pipe_valid_reg;
        if (in_ready)
            pipe_valid_next = in_valid;
    end

    always_comb
    begin
        // a start word clears everything before it is counted
        act     = start_reg || active_reg;
        tick_b  = start_reg ? '0 : tick_reg;
        cur_b   = start_reg ? '0 : cur_reg;
        prev_b  = start_reg ? '0 : prev_reg;
        old_b   = start_reg ? '0 : old_reg;
        bn_b    = start_reg ? '0 : bn_reg;
        found_b = start_reg ? 1'b0 : found_reg;

        span     = (cfg.samples_per_bucket == '0) ? SPB_W'(1) : cfg.samples_per_bucket;
        cur_inc  = cur_b + CNT_W'(edge_reg);
        tick_inc = tick_b + CNT_W'(1);
        complete = (tick_inc >= span);
        w        = bn_b - BN_W'(2);
        sum      = SUM_W'(old_b) + SUM_W'(prev_b) + SUM_W'(cur_inc);
        hit      = (bn_b >= BN_W'(2)) && !found_b && (SB_W'(w) >= cfg.start_bucket)
                   && (sum >= cfg.hit_threshold);

        active_next = active_reg;
        tick_next   = tick_reg;
        bn_next     = bn_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        old_next    = old_reg;
        found_next  = found_reg;
        idx_next    = idx_reg;
        res.valid   = 1'b0;
        res.bucket  = found_b ? $signed(OUT_W'(idx_reg)) : ECHO_NONE;

        if (step_en && act)
        begin
            active_next = 1'b1;
            if (!complete)
            begin
                tick_next  = tick_inc;
                cur_next   = cur_inc;
                prev_next  = prev_b;
                old_next   = old_b;
                bn_next    = bn_b;
                found_next = found_b;
                idx_next   = start_reg ? '0 : idx_reg;
            end
            else
            begin
                found_next = found_b || hit;
                idx_next   = hit ? w : (start_reg ? '0 : idx_reg);
                old_next   = prev_b;
                prev_next  = cur_inc;
                cur_next   = '0;
                tick_next  = '0;
                if (bn_b >= LAST_BUCKET)
                begin
                    bn_next     = bn_b;
                    active_next = 1'b0;
                    res.valid   = 1'b1;
                    res.bucket  = found_next ? $signed(OUT_W'(idx_next)) : ECHO_NONE;
                end
                else
                begin
                    bn_next = bn_b + BN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_valid_reg <= 1'b0;
            active_reg     <= 1'b0;
            tick_reg       <= '0;
            bn_reg         <= '0;
            cur_reg        <= '0;
            prev_reg       <= '0;
            old_reg        <= '0;
            found_reg      <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            pipe_valid_reg <= pipe_valid_next;
            active_reg     <= active_next;
            tick_reg       <= tick_next;
            bn_reg         <= bn_next;
            cur_reg        <= cur_next;
            prev_reg       <= prev_next;
            old_reg        <= old_next;
            found_reg      <= found_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            start_reg <= start_req;
            edge_reg  <= edge_req;
        end
    end

endmodule

### hdl/ebwd_out_buf.sv
module ebwd_out_buf (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ebwd_pkg::res_t                 res,
    output logic                          res_space,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [ebwd_pkg::OUT_W-1:0] echo_bucket
);
    import ebwd_pkg::*;

    logic                    main_valid_reg, main_valid_next;
    logic signed [OUT_W-1:0] main_data_reg, main_data_next;
    logic                    skid_valid_reg, skid_valid_next;
    logic signed [OUT_W-1:0] skid_data_reg, skid_data_next;
    logic                    pop;

    assign res_space   = !skid_valid_reg;
    assign out_valid   = main_valid_reg;
    assign echo_bucket = main_data_reg;
    assign pop         = main_valid_reg && out_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (main_valid_reg && !pop)
        begin
            if (res.valid)
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = res.bucket;
            end
        end
        else if (skid_valid_reg)
        begin
            // skid is full, so no new word arrives this cycle
            main_valid_next = 1'b1;
            main_data_next  = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        else
        begin
            main_valid_next = res.valid;
            main_data_next  = res.bucket;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

### hdl/echo_bucket_window_detector.sv
// Echo time-of-flight detector. Send one comparator sample per cycle on the
// input channel: start_req=1 opens a measurement (that word is its first
// sample), edge_req=1 counts one hit. The measurement spans NUM_BUCKETS
// buckets of samples_per_bucket samples each (0 acts as 1); when it ends, one
// word leaves on the output channel: echo_bucket is the first window start
// (at or after start_bucket) whose three-bucket hit sum reaches
// hit_threshold, or -1. Samples outside a measurement are dropped silently.
// Throughput is one sample per cycle while the output buffer has space. The
// final sample passes the input register and then the output register on its
// way to echo_bucket. A two-entry output buffer keeps samples flowing while a
// result waits. Write configuration only while idle; the config port is always
// ready and ignores unknown indexes.
module echo_bucket_window_detector (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                start_req,
    input  logic                                edge_req,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [ebwd_pkg::OUT_W-1:0]   echo_bucket,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ebwd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ebwd_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ebwd_pkg::*;

    cfg_t cfg;     // live register values
    res_t res;     // result word from the core
    logic res_space;

    ebwd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // bucket counters, window sum and first-hit capture
    ebwd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .start_req (start_req),
        .edge_req  (edge_req),
        .res_space (res_space),
        .res       (res)
    );

    // output register plus skid entry
    ebwd_out_buf u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .res         (res),
        .res_space   (res_space),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .echo_bucket (echo_bucket)
    );

endmodule

### hdl/ebwd_checker.sv
`include "echo_bucket_window_detector_macros.svh"

module ebwd_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [ebwd_pkg::OUT_W-1:0] echo_bucket
);
    import ebwd_pkg::*;

    localparam logic [OUT_W-1:0] LAST_START = OUT_W'(NUM_BUCKETS - 3);

    logic in_stall;
    logic out_stall;
    logic out_neg;
    logic out_pos;

    assign in_stall  = in_valid && !in_ready;
    assign out_stall = out_valid && !out_ready;
    assign out_neg   = out_valid && echo_bucket[OUT_W-1];
    assign out_pos   = out_valid && !echo_bucket[OUT_W-1];

    // a stalled result holds
    `EBWD_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(echo_bucket), "result moved")
    // the only negative result is the no-echo code
    `EBWD_ASSERT_NOW(a_neg_code, out_neg, echo_bucket == ECHO_NONE, "bad negative result")
    // a found window starts no later than three buckets from the end
    `EBWD_ASSERT_NOW(a_pos_range, out_pos, echo_bucket <= LAST_START, "start out of range")
    // no result straight out of reset
    `EBWD_ASSERT_ALWAYS(a_reset_quiet, $past(!rst_n), !out_valid, "result valid after reset")
    // input only backs up behind a waiting result
    `EBWD_ASSERT_NOW(a_stall_cause, in_stall, out_valid, "input stalled, no result held")

endmodule

bind echo_bucket_window_detector ebwd_checker u_ebwd_checker (.*);

### tb/sv/ebwd_checker.sv
module ebwd_scoreboard (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                start_req,
    input  logic                                edge_req,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [ebwd_pkg::OUT_W-1:0]   echo_bucket,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [ebwd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ebwd_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                  fails,
    output int                                  owed
);

    import ebwd_pkg::*;

    typedef logic signed [OUT_W-1:0] echo_t;

    // shadow registers
    logic [SPB_W-1:0] span_reg;
    logic [SB_W-1:0]  floor_reg;
    logic [THR_W-1:0] thresh_reg;

    // shadow measurement state
    logic             running;
    logic [SPB_W-1:0] ticks;
    logic [BN_W-1:0]  bucket;
    logic [CNT_W-1:0] hits_now;
    logic [CNT_W-1:0] hits_prev;
    logic [CNT_W-1:0] hits_old;
    logic             found;
    logic [BN_W-1:0]  found_at;

    echo_t echo_due[$];
    int    mismatches = 0;

    assign fails = mismatches;

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic void clear_counts();
        running   = 1'b0;
        ticks     = '0;
        bucket    = '0;
        hits_now  = '0;
        hits_prev = '0;
        hits_old  = '0;
        found     = 1'b0;
        found_at  = '0;
    endfunction

    // One sample word; queues the echo bucket when the last bucket closes.
    function automatic void advance_measurement(input logic first, input logic hit);
        logic [SPB_W-1:0] span;
        logic [SUM_W-1:0] window_sum;
        span = (span_reg == '0) ? SPB_W'(1) : span_reg;
        if (first)
        begin
            clear_counts();
            running = 1'b1;
        end
        if (running)
        begin
            hits_now = hits_now + CNT_W'(hit);
            ticks    = ticks + SPB_W'(1);
            if (ticks >= span)
            begin
                if (bucket >= BN_W'(2) && !found)
                begin
                    window_sum = SUM_W'(hits_old) + SUM_W'(hits_prev) + SUM_W'(hits_now);
                    if (bucket - BN_W'(2) >= floor_reg && window_sum >= thresh_reg)
                    begin
                        found    = 1'b1;
                        found_at = bucket - BN_W'(2);
                    end
                end
                hits_old  = hits_prev;
                hits_prev = hits_now;
                hits_now  = '0;
                ticks     = '0;
                if (bucket == LAST_BUCKET)
                begin
                    echo_due.push_back(found ? echo_t'({1'b0, found_at}) : ECHO_NONE);
                    running = 1'b0;
                end
                else
                begin
                    bucket = bucket + BN_W'(1);
                end
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        echo_t want;
        if (!rst_n)
        begin
            span_reg   = SPB_RESET;
            floor_reg  = SB_RESET;
            thresh_reg = THR_RESET;
            clear_counts();
            echo_due.delete();
            owed <= 0;
        end
        else
        begin
            // results leave only after their last sample is registered, so pop first
            if (out_valid && out_ready)
            begin
                if (echo_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected echo_bucket %0d", echo_bucket));
                end
                else
                begin
                    want = echo_due.pop_front();
                    if (echo_bucket !== want)
                    begin
                        report_mismatch($sformatf("echo_bucket %0d, want %0d",
                                                  echo_bucket, want));
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                advance_measurement(start_req, edge_req);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SAMPLES_PER_BUCKET: span_reg   = cfg_data[SPB_W-1:0];
                    CFG_START_BUCKET:       floor_reg  = cfg_data[SB_W-1:0];
                    CFG_HIT_THRESHOLD:      thresh_reg = cfg_data[THR_W-1:0];
                    default:                ;
                endcase
            end
            owed <= echo_due.size();
        end
    end

endmodule

### tb/sv/tb_top.sv
// Testbench for the echo window detector.
// The top only makes stimulus and gives the verdict; ebwd_scoreboard watches all
// three channels, predicts every echo_bucket word and compares in order.
// Stimulus: a directed part (reset start bucket and threshold, zero span,
// unreachable start bucket and threshold, a threshold that needs three full
// buckets, restarts, stray samples), then random phases of measurements, some
// cut short, with random registers, mostly short spans so that results come
// often. The first random phase holds the receiver off for a long stretch; a
// closing measurement runs with no idling.
module tb_top;

    import ebwd_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 9;
    localparam int LONG_HOLD      = 400;   // receiver hold-off, forces input stall
    localparam int DRAIN_CYCLES   = 8;     // settling time once no word is owed
    localparam int WATCHDOG_LIMIT = 5000;  // cycles without any handshake
    localparam int RANDOM_ITEMS   = 750;
    localparam int RANDOM_ECHOES  = 6;

    // index the block must ignore
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    logic                    start_req = 1'b0;
    logic                    edge_req  = 1'b0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [OUT_W-1:0] echo_bucket;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;

    int fails;
    int owed;

    // pacing knobs, changed per phase
    logic quiet      = 1'b0;   // no idling at all on either side
    int   tx_gap_pct = 10;
    int   rx_gap_pct = 10;
    int   hold_asks  = 0;      // bumped by stimulus to ask for a long hold-off
    int   hold_done  = 0;
    int   rx_wait    = 0;

    int cur_span = SPB_RESET;  // effective samples per bucket
    int random_items;
    int echoes_sent;           // complete measurements sent
    int stuck = 0;

    always #HALF_PERIOD clk = ~clk;

    echo_bucket_window_detector dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .start_req   (start_req),
        .edge_req    (edge_req),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .echo_bucket (echo_bucket),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    ebwd_scoreboard chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .start_req   (start_req),
        .edge_req    (edge_req),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .echo_bucket (echo_bucket),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fails       (fails),
        .owed        (owed)
    );

    // Receiver: short random stalls, or one long hold-off when asked.
    // The long one lets the output buffer fill so in_ready drops.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait   <= 0;
        end
        else if (rx_wait != 0)
        begin
            out_ready <= 1'b0;
            rx_wait   <= rx_wait - 1;
        end
        else if (hold_asks != hold_done)
        begin
            out_ready <= 1'b0;
            rx_wait   <= LONG_HOLD;
            hold_done <= hold_asks;
        end
        else if (!quiet && $urandom_range(0, 99) < rx_gap_pct)
        begin
            out_ready <= 1'b0;
            rx_wait   <= $urandom_range(0, 2);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            stuck <= 0;
        end
        else if (stuck == WATCHDOG_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            stuck <= stuck + 1;
        end
    end

    // One config word; valid drops after it, so back-to-back
    // writes never lower and raise valid in the same step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Junk above a register's width is legal on the bus and must be dropped.
    task automatic set_config(input int spb, input int first, input int thr);
        write_reg(CFG_SAMPLES_PER_BUCKET, spb);
        write_reg(CFG_START_BUCKET, first);
        write_reg(CFG_HIT_THRESHOLD, thr);
        cur_span = (spb % 256 == 0) ? 1 : spb % 256;
    endtask

    // One sample word, with an optional idle burst in front of it.
    task automatic push_sample(input logic first, input logic hit);
        int gap;
        if (!quiet && $urandom_range(0, 99) < tx_gap_pct)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        start_req <= first;
        edge_req  <= hit;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // A measurement: start on the first sample, hits dense in three buckets
    // from hot on and sparse elsewhere. A nonzero cut stops early; the next
    // start then drops the running measurement.
    task automatic run_measurement(input int cut, input int hot, input int hot_pct,
                                   input int base_pct);
        int length;
        int pct;
        length = (cut > 0) ? cut : NUM_BUCKETS * cur_span;
        for (int i = 0; i < length; i++)
        begin
            pct = (i / cur_span >= hot && i / cur_span <= hot + 2) ? hot_pct : base_pct;
            push_sample(i == 0, $urandom_range(0, 99) < pct);
        end
        random_items += length;
        if (cut == 0)
        begin
            echoes_sent++;
        end
    endtask

    task automatic random_measurement(input int cut);
        run_measurement(cut, $urandom_range(0, NUM_BUCKETS - 1), $urandom_range(30, 100),
                        $urandom_range(0, 25));
    endtask

    // Samples with no measurement running: the block drops them.
    task automatic stray_samples(input int count);
        repeat (count) push_sample(1'b0, $urandom_range(0, 1) == 1);
    endtask

    // Sender pause: wait for every owed word, then let the pipe go quiet.
    // The first edge lets the checker count the last accepted sample.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (owed != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic pick_pacing();
        case ($urandom_range(0, 2))
            0:       tx_gap_pct <= 0;
            1:       tx_gap_pct <= 10;
            default: tx_gap_pct <= 35;
        endcase
        case ($urandom_range(0, 2))
            0:       rx_gap_pct <= 0;
            1:       rx_gap_pct <= 10;
            default: rx_gap_pct <= 35;
        endcase
    endtask

    initial
    begin
        int phase;
        int spb;
        int first;
        int thr;
        int runs;
        logic hold;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed ----
        // unknown index first: reset values must survive it
        write_reg(CFG_UNUSED, $urandom_range(0, 1023));

        // reset start bucket 6 and threshold 8, with a short span so that
        // three full buckets can reach the threshold
        write_reg(CFG_SAMPLES_PER_BUCKET, 3);
        cur_span = 3;
        stray_samples(3);
        run_measurement(0, 10, 100, 1);
        wait_idle();

        // zero span acts as one; zero threshold takes the first allowed window;
        // a restart drops the running measurement
        set_config(0, 0, 0);
        run_measurement(7, 0, 0, 0);
        run_measurement(0, 5, 50, 0);
        stray_samples(2);
        wait_idle();

        // start buckets past the last window: never an echo
        set_config(1, 30, 0);
        run_measurement(0, 0, 100, 100);
        wait_idle();
        write_reg(CFG_START_BUCKET, 31);
        run_measurement(0, 0, 100, 100);
        wait_idle();

        // last reachable window
        set_config(1, 29, 3);
        run_measurement(0, 29, 100, 0);
        wait_idle();

        // thresholds above any possible sum
        set_config(2, 0, 766);
        run_measurement(0, 0, 100, 100);
        wait_idle();
        write_reg(CFG_HIT_THRESHOLD, 1023);
        run_measurement(0, 0, 100, 100);
        wait_idle();

        // threshold that only three full buckets reach
        set_config(4, 17, 12);
        run_measurement(0, 17, 100, 10);
        wait_idle();

        // ---- random phases ----
        random_items = 0;
        echoes_sent  = 0;
        phase        = 0;
        while (random_items < RANDOM_ITEMS || echoes_sent < RANDOM_ECHOES)
        begin
            hold = (phase == 0);
            if (random_items >= RANDOM_ITEMS - 200 && echoes_sent >= RANDOM_ECHOES - 8)
            begin
                quiet <= 1'b1;
            end
            if (!hold)
            begin
                pick_pacing();
            end

            case ($urandom_range(0, 9))
                0:       spb = 0;
                1, 2:    spb = $urandom_range(3, 12);
                default: spb = $urandom_range(1, 2);
            endcase
            if (hold)
            begin
                spb = 1;
                tx_gap_pct <= 0;
            end
            first = $urandom_range(0, 31);
            thr   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                    : $urandom_range(0, 3 * ((spb == 0) ? 1 : spb) + 1);
            // random high bits above the register widths
            set_config(spb + 256 * $urandom_range(0, 3), first + 32 * $urandom_range(0, 31),
                       thr);

            if (hold)
            begin
                hold_asks <= hold_asks + 1;
            end
            runs = hold ? 8 : $urandom_range(1, 3);
            for (int m = 0; m < runs; m++)
            begin
                if (m < runs - 1 && !hold && $urandom_range(0, 3) == 0)
                begin
                    random_measurement($urandom_range(1, NUM_BUCKETS * cur_span - 1));
                end
                else
                begin
                    random_measurement(0);
                    if ($urandom_range(0, 2) == 0)
                    begin
                        stray_samples($urandom_range(1, 4));
                    end
                end
            end
            wait_idle();
            phase++;
        end

        // closing measurement with no idling on either side
        quiet <= 1'b1;
        random_measurement(0);
        wait_idle();

        if (owed != 0)
        begin
            $display("%0d expected echo words never arrived", owed);
        end
        if (fails == 0 && owed == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
